// ----- sv/rci_pkg.sv -----
package rci_pkg;

    localparam int IN_W      = 192;
    localparam int OUT_W     = 72;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int Q_W       = 32;
    localparam int ROOT_W    = 32;
    localparam int RAD_W     = 64;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONE_MIN = 2'd0,
        REG_CONE_MAX = 2'd1,
        REG_EPSILON  = 2'd2
    } cfg_reg_t;

    // per-item context that rides along the long units
    typedef struct packed {
        logic               single;
        logic               ok;
        logic signed [31:0] oy;
        logic signed [31:0] dy;
        logic signed [31:0] h;
        logic signed [31:0] a;
        logic signed [31:0] c;
    } rci_side_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647)
        begin
            r = SAT_MAX;
        end
        else if (x < -66'sd2147483648)
        begin
            r = SAT_MIN;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/rci_sqrt.sv -----
module rci_sqrt #(
    parameter int SW = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [rci_pkg::RAD_W-1:0]  in_val,
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    output logic [rci_pkg::ROOT_W-1:0] out_root,
    output logic [SW-1:0]              out_side
);
    import rci_pkg::*;

    localparam int ST = ROOT_W;

    logic [RAD_W-1:0]  r_reg    [0:ST-1];
    logic [ROOT_W-1:0] q_reg    [0:ST-1];
    logic [SW-1:0]     side_reg [0:ST-1];
    logic              v_reg    [0:ST-1];

    genvar j;
    generate
        for (j = 0; j < ST; j++)
        begin : g_stage
            localparam int B = ST - 1 - j;
            logic [RAD_W-1:0]  r_in;
            logic [ROOT_W-1:0] q_in;
            logic [SW-1:0]     side_in;
            logic              v_in;
            logic [RAD_W:0]    trial;
            logic              take;
            logic [RAD_W-1:0]  r_next;
            logic [ROOT_W-1:0] q_next;

            if (j == 0)
            begin : g_first
                assign r_in    = in_val;
                assign q_in    = '0;
                assign side_in = in_side;
                assign v_in    = in_valid;
            end
            else
            begin : g_rest
                assign r_in    = r_reg[j-1];
                assign q_in    = q_reg[j-1];
                assign side_in = side_reg[j-1];
                assign v_in    = v_reg[j-1];
            end

            // (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
            always_comb
            begin
                trial  = ((RAD_W+1)'(q_in) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));
                take   = (RAD_W+1)'(r_in) >= trial;
                r_next = take ? (r_in - trial[RAD_W-1:0]) : r_in;
                q_next = q_in;
                q_next[B] = take;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[j] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[j] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[j]    <= r_next;
                    q_reg[j]    <= q_next;
                    side_reg[j] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[ST-1];
    assign out_root  = q_reg[ST-1];
    assign out_side  = side_reg[ST-1];

endmodule

// ----- sv/rci_div.sv -----
module rci_div #(
    parameter int NW = 49,
    parameter int DW = 34,
    parameter int SW = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [NW-1:0]                  num0,
    input  logic [NW-1:0]                  num1,
    input  logic [DW-1:0]                  den,
    input  logic                           neg0,
    input  logic                           neg1,
    input  logic [SW-1:0]                  in_side,
    output logic                           out_valid,
    output logic signed [rci_pkg::Q_W-1:0] q0,
    output logic signed [rci_pkg::Q_W-1:0] q1,
    output logic [SW-1:0]                  out_side
);
    import rci_pkg::*;

    localparam int WW = ((NW > DW + Q_W) ? NW : (DW + Q_W)) + 1;
    localparam int ST = Q_W;

    // index 0 is the overflow check stage, k+1 is after quotient bit ST-1-k
    logic [WW-1:0]  rem0_reg [0:ST];
    logic [WW-1:0]  rem1_reg [0:ST];
    logic [Q_W-1:0] q0_reg   [0:ST];
    logic [Q_W-1:0] q1_reg   [0:ST];
    logic [DW-1:0]  den_reg  [0:ST];
    logic           ovf0_reg [0:ST];
    logic           ovf1_reg [0:ST];
    logic           neg0_reg [0:ST];
    logic           neg1_reg [0:ST];
    logic [SW-1:0]  side_reg [0:ST];
    logic           v_reg    [0:ST];

    logic [WW-1:0]  den_top;
    logic signed [Q_W-1:0] q0_next, q1_next;
    logic signed [Q_W-1:0] q0_out_reg, q1_out_reg;
    logic [SW-1:0]  side_out_reg;
    logic           v_out_reg;

    function automatic logic signed [Q_W-1:0] fix(input logic [Q_W-1:0] q,
                                                  input logic ovf, input logic neg);
        logic signed [Q_W-1:0] r;
        if (ovf)
        begin
            r = neg ? SAT_MIN : SAT_MAX;
        end
        else if (!neg)
        begin
            r = q[Q_W-1] ? SAT_MAX : q;
        end
        else if (q > {1'b1, {(Q_W-1){1'b0}}})
        begin
            r = SAT_MIN;
        end
        else
        begin
            r = -q;
        end
        return r;
    endfunction

    assign den_top = WW'(den) << Q_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem0_reg[0] <= WW'(num0);
            rem1_reg[0] <= WW'(num1);
            q0_reg[0]   <= '0;
            q1_reg[0]   <= '0;
            den_reg[0]  <= den;
            ovf0_reg[0] <= WW'(num0) >= den_top;
            ovf1_reg[0] <= WW'(num1) >= den_top;
            neg0_reg[0] <= neg0;
            neg1_reg[0] <= neg1;
            side_reg[0] <= in_side;
        end
    end

    genvar k;
    generate
        for (k = 0; k < ST; k++)
        begin : g_stage
            localparam int B = ST - 1 - k;
            logic [WW-1:0]  sh;
            logic           take0, take1;
            logic [WW-1:0]  r0_next, r1_next;
            logic [Q_W-1:0] qa_next, qb_next;

            always_comb
            begin
                sh      = WW'(den_reg[k]) << B;
                take0   = rem0_reg[k] >= sh;
                take1   = rem1_reg[k] >= sh;
                r0_next = take0 ? (rem0_reg[k] - sh) : rem0_reg[k];
                r1_next = take1 ? (rem1_reg[k] - sh) : rem1_reg[k];
                qa_next = q0_reg[k];
                qb_next = q1_reg[k];
                qa_next[B] = take0;
                qb_next[B] = take1;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k+1] <= v_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem0_reg[k+1] <= r0_next;
                    rem1_reg[k+1] <= r1_next;
                    q0_reg[k+1]   <= qa_next;
                    q1_reg[k+1]   <= qb_next;
                    den_reg[k+1]  <= den_reg[k];
                    ovf0_reg[k+1] <= ovf0_reg[k];
                    ovf1_reg[k+1] <= ovf1_reg[k];
                    neg0_reg[k+1] <= neg0_reg[k];
                    neg1_reg[k+1] <= neg1_reg[k];
                    side_reg[k+1] <= side_reg[k];
                end
            end
        end
    endgenerate

    // sign and saturation
    always_comb
    begin
        q0_next = fix(q0_reg[ST], ovf0_reg[ST], neg0_reg[ST]);
        q1_next = fix(q1_reg[ST], ovf1_reg[ST], neg1_reg[ST]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_out_reg <= 1'b0;
        end
        else if (en)
        begin
            v_out_reg <= v_reg[ST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_out_reg   <= q0_next;
            q1_out_reg   <= q1_next;
            side_out_reg <= side_reg[ST];
        end
    end

    assign out_valid = v_out_reg;
    assign q0        = q0_out_reg;
    assign q1        = q1_out_reg;
    assign out_side  = side_out_reg;

endmodule

// ----- sv/ray_cone_intersect.sv -----
// throughput: one item per cycle while the pipeline is not held; the 32-stage square root
// and the 34-stage divider are fully pipelined, so each takes a new item every cycle
// the pipeline holds only while the two-entry output buffer is full
// reset (rst_n low, asynchronous) empties every stage and the output buffer and sets
// cone_min to -2^31, cone_max to 2^31-1 and epsilon to 7
module ray_cone_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
    input  logic [rci_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit_count (2), t_first (32), t_second (32), zero fill (6)
    output logic [rci_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          cfg_we,
    input  logic [rci_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rci_pkg::CFG_W-1:0]     cfg_wdata
);
    import rci_pkg::*;

    localparam int NW = 33 + FRAC_BITS;   // numerator magnitude incl. fraction shift
    localparam int DW = 34;               // |4h| needs 34 bits
    localparam int SW = $bits(rci_side_t);

    // configuration registers
    logic signed [31:0] cone_min_reg, cone_max_reg;
    logic [15:0]        eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cone_min_reg <= SAT_MIN;
            cone_max_reg <= SAT_MAX;
            eps_reg      <= 16'd7;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CONE_MIN: cone_min_reg <= cfg_wdata;
                REG_CONE_MAX: cone_max_reg <= cfg_wdata;
                REG_EPSILON:  eps_reg      <= cfg_wdata[15:0];
                default:      ;
            endcase
        end
    end

    // global advance: the whole pipeline moves unless the output skid holds an item
    logic en;
    logic out_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0] out_data_reg, skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- stage 1: the nine products ----------------
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
    assign ox = s_tdata[31:0];
    assign oy = s_tdata[63:32];
    assign oz = s_tdata[95:64];
    assign dx = s_tdata[127:96];
    assign dy = s_tdata[159:128];
    assign dz = s_tdata[191:160];

    // order: dx*dx, dy*dy, dz*dz, ox*dx, oy*dy, oz*dz, ox*ox, oy*oy, oz*oz
    logic signed [63:0] prod_next [0:8];
    logic signed [63:0] prod_reg  [0:8];
    logic signed [31:0] oy1_reg, dy1_reg;
    logic               v1_reg;

    always_comb
    begin
        prod_next[0] = dx * dx;
        prod_next[1] = dy * dy;
        prod_next[2] = dz * dz;
        prod_next[3] = ox * dx;
        prod_next[4] = oy * dy;
        prod_next[5] = oz * dz;
        prod_next[6] = ox * ox;
        prod_next[7] = oy * oy;
        prod_next[8] = oz * oz;
    end

    // ---------------- stage 2: a, h (half of b), c ----------------
    logic signed [65:0] a_sum, h_sum, c_sum;
    logic signed [31:0] a2_reg, h2_reg, c2_reg, oy2_reg, dy2_reg;
    logic               v2_reg;

    // products are floored back to the fraction grid, then summed exactly
    always_comb
    begin
        a_sum = 66'(prod_reg[0] >>> FRAC_BITS) - 66'(prod_reg[1] >>> FRAC_BITS)
              + 66'(prod_reg[2] >>> FRAC_BITS);
        h_sum = 66'(prod_reg[3] >>> FRAC_BITS) - 66'(prod_reg[4] >>> FRAC_BITS)
              + 66'(prod_reg[5] >>> FRAC_BITS);
        c_sum = 66'(prod_reg[6] >>> FRAC_BITS) - 66'(prod_reg[7] >>> FRAC_BITS)
              + 66'(prod_reg[8] >>> FRAC_BITS);
    end

    // ---------------- stage 3: h*h, a*c and the near-zero tests ----------------
    logic signed [32:0] a_ext, abs_a;
    logic signed [33:0] h2x, abs_h2x;
    logic               near_a_next, single_ok_next;
    logic signed [63:0] hh_reg, ac_reg;
    rci_side_t          side3_reg;
    logic               v3_reg;

    always_comb
    begin
        a_ext   = 33'(a2_reg);
        abs_a   = a_ext[32] ? -a_ext : a_ext;
        h2x     = 34'(h2_reg) <<< 1;
        abs_h2x = h2x[33] ? -h2x : h2x;
        // a near zero: only the linear root t = -c / (4h) is left
        near_a_next    = (a2_reg == 32'sd0) || (abs_a < $signed({17'd0, eps_reg}));
        // b near zero on that path: no hit at all
        single_ok_next = (h2_reg != 32'sd0) && (abs_h2x >= $signed({18'd0, eps_reg}));
    end

    // ---------------- stage 4: discriminant ----------------
    logic signed [64:0] disc;
    logic [RAD_W-1:0]   rad_next;
    rci_side_t          side4_next;
    logic [RAD_W-1:0]   rad4_reg;
    rci_side_t          side4_reg;
    logic               v4_reg;

    always_comb
    begin
        disc       = 65'(hh_reg) - 65'(ac_reg);
        rad_next   = disc[64] ? '0 : disc[RAD_W-1:0];
        side4_next = side3_reg;
        // negative discriminant: the ray misses the cone
        side4_next.ok = side3_reg.single ? side3_reg.ok : !disc[64];
    end

    // ---------------- square root unit ----------------
    logic              v_sq;
    logic [ROOT_W-1:0] root;
    logic [SW-1:0]     side_sq_bits;
    rci_side_t         side_sq;

    rci_sqrt #(.SW(SW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_val    (rad4_reg),
        .in_side   (side4_reg),
        .out_valid (v_sq),
        .out_root  (root),
        .out_side  (side_sq_bits)
    );

    assign side_sq = rci_side_t'(side_sq_bits);

    // ---------------- stage 5: numerators and divisor ----------------
    logic signed [33:0] h34, s34, n0, n1, dsel, abs_n0, abs_n1, abs_d;
    logic [NW-1:0]      num0_next, num1_next;
    logic [NW-1:0]      num0_reg, num1_reg;
    logic [DW-1:0]      den_reg;
    logic               neg0_reg, neg1_reg;
    rci_side_t          side5_reg;
    logic               v5_reg;

    always_comb
    begin
        h34 = 34'(side_sq.h);
        s34 = $signed({2'b00, root});
        if (side_sq.single)
        begin
            n0   = -34'(side_sq.c);
            n1   = n0;
            dsel = h34 <<< 2;
        end
        else
        begin
            n0   = -h34 - s34;
            n1   = -h34 + s34;
            dsel = 34'(side_sq.a);
        end
        abs_n0    = n0[33] ? -n0 : n0;
        abs_n1    = n1[33] ? -n1 : n1;
        abs_d     = dsel[33] ? -dsel : dsel;
        num0_next = NW'(abs_n0[32:0]) << FRAC_BITS;
        num1_next = NW'(abs_n1[32:0]) << FRAC_BITS;
    end

    // ---------------- divider unit, two lanes sharing the divisor ----------------
    logic               v_dv;
    logic signed [31:0] q0, q1;
    logic [SW-1:0]      side_dv_bits;
    rci_side_t          side_dv;

    rci_div #(.NW(NW), .DW(DW), .SW(SW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .num0      (num0_reg),
        .num1      (num1_reg),
        .den       (den_reg),
        .neg0      (neg0_reg),
        .neg1      (neg1_reg),
        .in_side   (side5_reg),
        .out_valid (v_dv),
        .q0        (q0),
        .q1        (q1),
        .out_side  (side_dv_bits)
    );

    assign side_dv = rci_side_t'(side_dv_bits);

    // ---------------- stage 6: larger root first ----------------
    logic signed [31:0] thi_reg, tlo_reg;
    rci_side_t          side6_reg;
    logic               v6_reg;

    // ---------------- stage 7: t * dy for the height test ----------------
    logic signed [63:0] yhi_prod_reg, ylo_prod_reg;
    logic signed [31:0] thi7_reg, tlo7_reg;
    rci_side_t          side7_reg;
    logic               v7_reg;

    // ---------------- stage 8: height window and hit list ----------------
    logic signed [64:0] y_hi, y_lo, lo_bound, hi_bound;
    logic               in_hi, in_lo;
    logic [1:0]         cnt_next;
    logic signed [31:0] first_next, second_next;
    logic [OUT_W-1:0]   res_next;
    logic [OUT_W-1:0]   res8_reg;
    logic               v8_reg;

    always_comb
    begin
        lo_bound    = 65'(cone_min_reg);
        hi_bound    = 65'(cone_max_reg);
        y_hi        = 65'(side7_reg.oy) + 65'(yhi_prod_reg >>> FRAC_BITS);
        y_lo        = 65'(side7_reg.oy) + 65'(ylo_prod_reg >>> FRAC_BITS);
        in_hi       = (y_hi > lo_bound) && (y_hi < hi_bound);
        in_lo       = (y_lo > lo_bound) && (y_lo < hi_bound);
        cnt_next    = 2'd0;
        first_next  = '0;
        second_next = '0;
        if (side7_reg.ok)
        begin
            if (side7_reg.single)
            begin
                // linear root is reported without the height test
                cnt_next   = 2'd1;
                first_next = thi7_reg;
            end
            else if (in_hi && in_lo)
            begin
                cnt_next    = 2'd2;
                first_next  = thi7_reg;
                second_next = tlo7_reg;
            end
            else if (in_hi)
            begin
                cnt_next   = 2'd1;
                first_next = thi7_reg;
            end
            else if (in_lo)
            begin
                cnt_next   = 2'd1;
                first_next = tlo7_reg;
            end
        end
        res_next = {6'd0, second_next, first_next, cnt_next};
    end

    // valid bits of the local stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v_sq;
            v6_reg <= v_dv;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            oy1_reg <= oy;
            dy1_reg <= dy;

            a2_reg  <= sat32(a_sum);
            h2_reg  <= sat32(h_sum);
            c2_reg  <= sat32(c_sum);
            oy2_reg <= oy1_reg;
            dy2_reg <= dy1_reg;

            hh_reg           <= h2_reg * h2_reg;
            ac_reg           <= a2_reg * c2_reg;
            side3_reg.single <= near_a_next;
            side3_reg.ok     <= single_ok_next;
            side3_reg.oy     <= oy2_reg;
            side3_reg.dy     <= dy2_reg;
            side3_reg.h      <= h2_reg;
            side3_reg.a      <= a2_reg;
            side3_reg.c      <= c2_reg;

            rad4_reg  <= rad_next;
            side4_reg <= side4_next;

            num0_reg  <= num0_next;
            num1_reg  <= num1_next;
            den_reg   <= abs_d;
            neg0_reg  <= n0[33] ^ dsel[33];
            neg1_reg  <= n1[33] ^ dsel[33];
            side5_reg <= side_sq;

            thi_reg   <= (q0 < q1) ? q1 : q0;
            tlo_reg   <= (q0 < q1) ? q0 : q1;
            side6_reg <= side_dv;

            yhi_prod_reg <= thi_reg * side6_reg.dy;
            ylo_prod_reg <= tlo_reg * side6_reg.dy;
            thi7_reg     <= thi_reg;
            tlo7_reg     <= tlo_reg;
            side7_reg    <= side6_reg;

            res8_reg <= res_next;
        end
    end

    // ---------------- output register plus skid entry ----------------
    logic push, pop;
    assign push = en && v8_reg;
    assign pop  = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push && out_valid_reg && !pop)
        begin
            skid_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push && out_valid_reg && !pop)
        begin
            skid_data_reg <= res8_reg;
        end
        else if (push)
        begin
            out_data_reg <= res8_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- sv/rci_check.sv -----
module rci_check (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [rci_pkg::OUT_W-1:0] m_tdata
);

    // a held result item stays put until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("hit count out of range");

    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == 2'd0 |-> m_tdata[65:2] == 64'd0)
        else $error("distances present with no hit");

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == 2'd1 |-> m_tdata[65:34] == 32'd0)
        else $error("second distance present with one hit");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == 2'd2 |-> $signed(m_tdata[33:2]) >= $signed(m_tdata[65:34]))
        else $error("two hits not ordered larger first");

endmodule

bind ray_cone_intersect rci_check u_rci_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
